FILE: rtl/msbuf_pkg.sv
package msbuf_pkg;

   // default sizes
   localparam int TOTAL_SLOTS_DEF = 16;
   localparam int STACK_COUNT_DEF = 4;
   localparam int DATA_WIDTH_DEF  = 32;

   // fixed field widths
   localparam int ID_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // capture request, read stack top
      logic lookup;   // pick slot, read link and data
      logic commit;   // write back, load result register
   } cmd_type;

endpackage

FILE: rtl/msbuf_ctrl.sv
module msbuf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msbuf_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // result register can take a new word
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // command decode and next state
   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/msbuf_datapath.sv
module msbuf_datapath #(
   parameter int TOTAL_SLOTS = msbuf_pkg::TOTAL_SLOTS_DEF,
   parameter int STACK_COUNT = msbuf_pkg::STACK_COUNT_DEF,
   parameter int DATA_WIDTH  = msbuf_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  msbuf_pkg::cmd_type                     cmd,
   input  logic                                   req_op,
   input  logic [msbuf_pkg::ID_W-1:0]             req_stack_id,
   input  logic signed [msbuf_pkg::VALUE_W-1:0]   req_push_value,
   output logic signed [msbuf_pkg::VALUE_W-1:0]   rsp_pop_value,
   output logic [msbuf_pkg::STATUS_W-1:0]         rsp_status
);

   // link codes hold a slot index or none (TOTAL_SLOTS)
   localparam int LINK_W = $clog2(TOTAL_SLOTS + 1);
   localparam int SLOT_W = $clog2(TOTAL_SLOTS);
   localparam int STK_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
   localparam logic [LINK_W-1:0] SLOT_NONE = LINK_W'(TOTAL_SLOTS);

   // slot and stack memories
   logic [DATA_WIDTH-1:0]  data_mem [TOTAL_SLOTS];
   logic [LINK_W-1:0]      link_mem [TOTAL_SLOTS];
   logic [LINK_W-1:0]      top_mem  [STACK_COUNT];
   logic [STACK_COUNT-1:0] top_vld_ff;

   // request capture
   logic                  op_ff;
   logic                  stk_ok_ff;
   logic [STK_W-1:0]      idx_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_trim;
   logic [STK_W-1:0]      req_idx;

   // registered memory reads
   logic [LINK_W-1:0]     top_rd_ff;
   logic                  top_rd_vld_ff;
   logic [LINK_W-1:0]     link_rd_ff;
   logic [DATA_WIDTH-1:0] data_rd_ff;

   // lookup results
   logic [LINK_W-1:0]     top_now;
   logic [LINK_W-1:0]     slot_sel;
   logic [LINK_W-1:0]     slot_ff;
   logic [LINK_W-1:0]     top_ff;
   logic                  fail_ff;
   logic                  fresh_ff;

   // free list: chained slots, then the never-used slots from fill_ff upward
   logic [LINK_W-1:0]     free_head_ff;
   logic [LINK_W-1:0]     free_head_in;
   logic [LINK_W-1:0]     fill_ff;
   logic [LINK_W-1:0]     fill_in;
   logic [LINK_W-1:0]     link_val;
   logic [SLOT_W-1:0]     slot_addr;
   logic [SLOT_W-1:0]     wr_addr;

   // result register
   logic signed [msbuf_pkg::VALUE_W-1:0] pop_value_ff;
   logic [msbuf_pkg::STATUS_W-1:0]       status_ff;
   logic [msbuf_pkg::VALUE_W-1:0]        data_ext;

   assign req_idx = STK_W'(req_stack_id);

   // fit push value to the slot width, and slot word back to 32 bits
   generate
      if (DATA_WIDTH <= msbuf_pkg::VALUE_W) begin : g_trim_narrow
         assign value_trim = req_push_value[DATA_WIDTH-1:0];
      end else begin : g_trim_wide
         assign value_trim = {{(DATA_WIDTH - msbuf_pkg::VALUE_W){1'b0}}, req_push_value};
      end
      if (DATA_WIDTH >= msbuf_pkg::VALUE_W) begin : g_ext_wide
         assign data_ext = data_rd_ff[msbuf_pkg::VALUE_W-1:0];
      end else begin : g_ext_narrow
         assign data_ext = {{(msbuf_pkg::VALUE_W - DATA_WIDTH){data_rd_ff[DATA_WIDTH-1]}},
                            data_rd_ff};
      end
   endgenerate

   // lookup stage: resolve top and pick the slot
   assign top_now   = top_rd_vld_ff ? top_rd_ff : SLOT_NONE;
   assign slot_sel  = (op_ff == msbuf_pkg::OP_PUSH) ? free_head_ff : top_now;
   assign slot_addr = slot_sel[SLOT_W-1:0];
   assign wr_addr   = slot_ff[SLOT_W-1:0];

   // a never-used slot links to the next index
   assign link_val  = fresh_ff ? (slot_ff + LINK_W'(1)) : link_rd_ff;

   // request capture and pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_op;
         stk_ok_ff <= (32'(req_stack_id) < STACK_COUNT);
         idx_ff    <= req_idx;
         value_ff  <= value_trim;
      end
      if (cmd.lookup) begin
         slot_ff  <= slot_sel;
         top_ff   <= top_now;
         fail_ff  <= !stk_ok_ff || (slot_sel == SLOT_NONE);
         fresh_ff <= (slot_sel >= fill_ff);
      end
   end

   // stack top memory
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         top_rd_ff <= top_mem[req_idx];
      end
      if (cmd.commit && !fail_ff) begin
         if (op_ff == msbuf_pkg::OP_PUSH) begin
            top_mem[idx_ff] <= slot_ff;
         end else begin
            top_mem[idx_ff] <= link_val;
         end
      end
   end

   // top valid bits: cleared at reset, an invalid top reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         top_vld_ff    <= '0;
         top_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            top_rd_vld_ff <= top_vld_ff[req_idx];
         end
         if (cmd.commit && !fail_ff) begin
            top_vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // slot link and data memories
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         link_rd_ff <= link_mem[slot_addr];
         data_rd_ff <= data_mem[slot_addr];
      end
      if (cmd.commit && !fail_ff) begin
         if (op_ff == msbuf_pkg::OP_PUSH) begin
            link_mem[wr_addr] <= top_ff;
            data_mem[wr_addr] <= value_ff;
         end else begin
            link_mem[wr_addr] <= free_head_ff;
         end
      end
   end

   // free head and fill count
   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      if (cmd.commit && !fail_ff) begin
         if (op_ff == msbuf_pkg::OP_PUSH) begin
            free_head_in = link_val;
            if (fresh_ff) begin
               fill_in = fill_ff + LINK_W'(1);
            end
         end else begin
            free_head_in = slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fill_ff      <= '0;
      end else begin
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (fail_ff) begin
            pop_value_ff <= '0;
            status_ff    <= (op_ff == msbuf_pkg::OP_POP) ? msbuf_pkg::ST_UNDERFLOW
                                                         : msbuf_pkg::ST_OVERFLOW;
         end else begin
            pop_value_ff <= (op_ff == msbuf_pkg::OP_POP) ? signed'(data_ext) : '0;
            status_ff    <= msbuf_pkg::ST_OK;
         end
      end
   end

   assign rsp_pop_value = pop_value_ff;
   assign rsp_status    = status_ff;

endmodule

FILE: rtl/multi_stack_shared_buffer_core.sv
// A word accepted in idle passes the lookup and commit states; the commit writes back
// and loads the result word. A new word is taken only once the last is written back;
// the top read, link read and write back form a serial read-modify-write over memory.
// A result held by rsp_ready low stalls the write back until the word is taken.
// Reset (synchronous, active high) empties all stacks at once; no clearing pass.
module multi_stack_shared_buffer_core #(
   parameter int TOTAL_SLOTS = msbuf_pkg::TOTAL_SLOTS_DEF,
   parameter int STACK_COUNT = msbuf_pkg::STACK_COUNT_DEF,
   parameter int DATA_WIDTH  = msbuf_pkg::DATA_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic [msbuf_pkg::ID_W-1:0]             req_stack_id,
   input  logic signed [msbuf_pkg::VALUE_W-1:0]   req_push_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [msbuf_pkg::VALUE_W-1:0]   rsp_pop_value,
   output logic [msbuf_pkg::STATUS_W-1:0]         rsp_status
);

   msbuf_pkg::cmd_type cmd;

   msbuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   msbuf_datapath #(
      .TOTAL_SLOTS (TOTAL_SLOTS),
      .STACK_COUNT (STACK_COUNT),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

endmodule

FILE: rtl/msbuf_checker.sv
module msbuf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   req_op,
   input logic [msbuf_pkg::ID_W-1:0]             req_stack_id,
   input logic signed [msbuf_pkg::VALUE_W-1:0]   req_push_value,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [msbuf_pkg::VALUE_W-1:0]   rsp_pop_value,
   input logic [msbuf_pkg::STATUS_W-1:0]         rsp_status
);

   // a stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_op) &&
                                  $stable(req_stack_id) && $stable(req_push_value))
      else $error("request word changed while stalled");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_value) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // one word in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one in flight");

   // failed operations return zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != msbuf_pkg::ST_OK) |-> rsp_pop_value == '0)
      else $error("nonzero value on failed operation");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == msbuf_pkg::ST_OK) ||
                    (rsp_status == msbuf_pkg::ST_OVERFLOW) ||
                    (rsp_status == msbuf_pkg::ST_UNDERFLOW))
      else $error("undefined status code");

endmodule

bind multi_stack_shared_buffer_core msbuf_checker u_checker (.*);

FILE: test/tb_multi_stack_shared_buffer_core.sv
`timescale 1ns / 100ps

module tb_multi_stack_shared_buffer_core;

   localparam int CLK_PERIOD      = 10;
   localparam int TOTAL_SLOTS     = msbuf_pkg::TOTAL_SLOTS_DEF;
   localparam int STACK_COUNT     = msbuf_pkg::STACK_COUNT_DEF;
   localparam int SLOT_W          = $clog2(TOTAL_SLOTS + 1);
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TOTAL_SLOTS);
   localparam int RANDOM_PER_PASS = 230;
   localparam int BURST_LEN       = 20;
   localparam int RSP_HOLD_CYCLES = 40;
   localparam int PRESSURE_WORDS  = 12;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 10;
   localparam int DIR_ROW_COUNT   = 25;

   // one result word
   typedef struct packed {
      logic [msbuf_pkg::VALUE_W-1:0]  pop_value;
      logic [msbuf_pkg::STATUS_W-1:0] status;
   } stack_result_type;

   // one directed stimulus row; typed rows carry their own expected word
   typedef struct packed {
      logic                           op;
      logic [msbuf_pkg::ID_W-1:0]     stack_id;
      logic [msbuf_pkg::VALUE_W-1:0]  push_value;
      logic                           typed;
      logic [msbuf_pkg::VALUE_W-1:0]  exp_value;
      logic [msbuf_pkg::STATUS_W-1:0] exp_status;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_ROW_COUNT] = '{
      // pops of empty stacks right after reset
      '{msbuf_pkg::OP_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h0, msbuf_pkg::ST_UNDERFLOW},
      '{msbuf_pkg::OP_POP,  2'd3, 32'hFFFF_FFFF, 1'b1, 32'h0, msbuf_pkg::ST_UNDERFLOW},
      // extreme values round trip
      '{msbuf_pkg::OP_PUSH, 2'd0, 32'h8000_0000, 1'b1, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd3, 32'h7FFF_FFFF, 1'b1, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_POP,  2'd3, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h0, msbuf_pkg::ST_UNDERFLOW},
      '{msbuf_pkg::OP_PUSH, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0, msbuf_pkg::ST_OK},
      // fill every remaining slot
      '{msbuf_pkg::OP_PUSH, 2'd0, 32'h0000_0000, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd1, 32'h0000_0001, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'hAAAA_AAAA, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd3, 32'h5555_5555, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd0, 32'hDEAD_BEEF, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd1, 32'h1234_5678, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'h8000_0001, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd3, 32'h7FFF_FFFE, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd0, 32'h0F0F_0F0F, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd1, 32'hF0F0_F0F0, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'h0000_FFFF, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd3, 32'hFFFF_0000, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'hCAFE_F00D, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'h3C3C_3C3C, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      '{msbuf_pkg::OP_PUSH, 2'd3, 32'hC3C3_C3C3, 1'b0, 32'h0, msbuf_pkg::ST_OK},
      // no slot left
      '{msbuf_pkg::OP_PUSH, 2'd2, 32'h1111_1111, 1'b1, 32'h0, msbuf_pkg::ST_OVERFLOW},
      '{msbuf_pkg::OP_POP,  2'd1, 32'h0000_0000, 1'b0, 32'h0, msbuf_pkg::ST_OK}
   };

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_op;
   logic [msbuf_pkg::ID_W-1:0]            req_stack_id;
   logic signed [msbuf_pkg::VALUE_W-1:0]  req_push_value;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [msbuf_pkg::VALUE_W-1:0]  rsp_pop_value;
   logic [msbuf_pkg::STATUS_W-1:0]        rsp_status;

   // typed expectation riding along with the current word
   logic                                  word_typed;
   stack_result_type                      word_typed_result;

   // shadow of the stack store
   logic [msbuf_pkg::VALUE_W-1:0]         shadow_data [TOTAL_SLOTS];
   logic [SLOT_W-1:0]                     shadow_link [TOTAL_SLOTS];
   logic [SLOT_W-1:0]                     shadow_top  [STACK_COUNT];
   logic [SLOT_W-1:0]                     shadow_free;

   stack_result_type                      results_due [$];
   int                                    mismatch_count = 0;
   int                                    send_idle_pct  = 0;
   int                                    recv_idle_pct  = 0;
   bit                                    hold_rsp       = 1'b0;

   multi_stack_shared_buffer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // empty stacks, every slot chained into the free list
   task automatic clear_shadow();
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         shadow_data[i] = '0;
         shadow_link[i] = SLOT_W'(i + 1);
      end
      for (int i = 0; i < STACK_COUNT; i++)
         shadow_top[i] = SLOT_NONE;
      shadow_free = '0;
   endtask

   // push/pop on the shadow store; DATA_WIDTH equals the port width here
   task automatic apply_stack_op(input logic op, input logic [msbuf_pkg::ID_W-1:0] id,
                                 input logic [msbuf_pkg::VALUE_W-1:0] value,
                                 output stack_result_type res);
      logic [SLOT_W-1:0] s;
      res = '{pop_value: '0, status: msbuf_pkg::ST_OK};
      if (op == msbuf_pkg::OP_PUSH) begin
         if (id >= STACK_COUNT || shadow_free == SLOT_NONE) begin
            res.status = msbuf_pkg::ST_OVERFLOW;
         end else begin
            s              = shadow_free;
            shadow_free    = shadow_link[s];
            shadow_data[s] = value;
            shadow_link[s] = shadow_top[id];
            shadow_top[id] = s;
         end
      end else begin
         if (id >= STACK_COUNT || shadow_top[id] == SLOT_NONE) begin
            res.status = msbuf_pkg::ST_UNDERFLOW;
         end else begin
            s              = shadow_top[id];
            shadow_top[id] = shadow_link[s];
            shadow_link[s] = shadow_free;
            shadow_free    = s;
            res.pop_value  = shadow_data[s];
         end
      end
   endtask

   task automatic note_mismatch(input string what, input stack_result_type exp_w,
                                input stack_result_type got_w);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected value %h status %0d, got value %h status %0d",
                  $realtime, what, exp_w.pop_value, exp_w.status,
                  got_w.pop_value, got_w.status);
   endtask

   // predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      stack_result_type predicted;
      stack_result_type observed;
      stack_result_type owed;
      if (reset) begin
         clear_shadow();
         results_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_stack_op(req_op, req_stack_id, req_push_value, predicted);
            if (word_typed)
               predicted = word_typed_result;
            results_due.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            observed = '{pop_value: rsp_pop_value, status: rsp_status};
            if (results_due.size() == 0) begin
               note_mismatch("unexpected word", '0, observed);
            end else begin
               owed = results_due.pop_front();
               if (observed.pop_value !== owed.pop_value)
                  note_mismatch("pop_value mismatch", owed, observed);
               else if (observed.status !== owed.status)
                  note_mismatch("status mismatch", owed, observed);
            end
         end
      end
   end

   // response side: random back-pressure plus one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // offer one word; entered and left at a falling edge
   task automatic send_word(input logic op, input logic [msbuf_pkg::ID_W-1:0] id,
                            input logic [msbuf_pkg::VALUE_W-1:0] value, input logic typed,
                            input stack_result_type typed_res);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_stack_id      <= id;
      req_push_value    <= value;
      word_typed        <= typed;
      word_typed_result <= typed_res;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random(input int push_pct);
      logic [msbuf_pkg::VALUE_W-1:0] value;
      logic [msbuf_pkg::VALUE_W-1:0] corner [4];
      corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      value  = ($urandom_range(7) == 0) ? corner[$urandom_range(3)] : $urandom;
      send_word(($urandom_range(99) < push_pct) ? msbuf_pkg::OP_PUSH : msbuf_pkg::OP_POP,
                msbuf_pkg::ID_W'($urandom_range(STACK_COUNT - 1)), value, 1'b0, '0);
   endtask

   // stimulus
   initial begin
      int push_mix [4];
      int push_pct;
      push_mix = '{15, 50, 75, 95};
      push_pct = 50;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = msbuf_pkg::OP_PUSH;
      req_stack_id      = '0;
      req_push_value    = '0;
      word_typed        = 1'b0;
      word_typed_result = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 22;
      recv_idle_pct = 60;

      // directed table
      foreach (DIR_ROWS[i])
         send_word(DIR_ROWS[i].op, DIR_ROWS[i].stack_id, DIR_ROWS[i].push_value,
                   DIR_ROWS[i].typed,
                   '{pop_value: DIR_ROWS[i].exp_value, status: DIR_ROWS[i].exp_status});

      // random passes: lopsided idling both ways, then none
      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 60;
            end
            1: begin
               // let everything drain before switching sides
               req_valid <= 1'b0;
               wait (results_due.size() == 0);
               @(negedge clock);
               send_idle_pct = 60;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long response stall while requests keep coming
               hold_rsp = 1'b1;
               for (int n = 0; n < PRESSURE_WORDS; n++)
                  send_random(60);
            end
         endcase
         // bursts lean toward pushes or pops to reach full and empty stacks
         for (int n = 0; n < RANDOM_PER_PASS; n++) begin
            if (n % BURST_LEN == 0)
               push_pct = push_mix[$urandom_range(3)];
            send_random(push_pct);
         end
      end

      req_valid <= 1'b0;
      wait (results_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
